// ===== hdl/ntpcal_pkg.sv =====
// ============================================================================
// ntpcal_pkg - shared constants for the NTP reply to calendar date block
// Header check values, reciprocal constants for the divide-by-constant
// steps, pipeline depth and the month start table.
// ============================================================================
`default_nettype none

package ntpcal_pkg;

  // Header checks
  localparam logic [15:0] NTP_PORT       = 16'd123;
  localparam logic [15:0] NTP_MIN_LENGTH = 16'd48;
  localparam logic [2:0]  NTP_MODE_SRV   = 3'd4;
  localparam logic [31:0] NTP_EPOCH_DELTA = 32'd2208988800;

  // Epoch delta less two days of bias, so the biased time is never negative
  localparam logic [32:0] BIASED_DELTA = 33'd2208816000;

  // Pipeline depth from accepted beat to result strobe
  localparam int unsigned LATENCY = 9;

  // Reciprocals: floor(x / d) = (x * R) >> K, exact over the used range
  localparam logic [24:0] RCP_675  = 25'd25451659;  // K = 34, x < 2^24
  localparam logic [15:0] RCP_15A  = 16'd34953;     // K = 19, x < 2^15
  localparam logic [9:0]  RCP_15B  = 10'd547;       // K = 13, x < 2^9
  localparam logic [15:0] RCP_365A = 16'd45965;     // K = 24, x < 2^16
  localparam logic [18:0] RCP_365B = 19'd367720;    // K = 27, x < 2^18
  // (5 * doy + 2) / 153 folded into one multiply-add, K = 19
  localparam logic [14:0] MP_MUL   = 15'd17135;
  localparam logic [23:0] MP_ADD   = 24'd6854;

  // Era split: z = q + 719466; era 5 starts at z = 730485
  localparam logic [14:0] ERA5_Q     = 15'd11019;
  localparam logic [17:0] ERA4_SHIFT = 18'd135078;

  // Day-of-era thresholds for the century correction
  localparam logic [17:0] DOE_C1 = 18'd36524;
  localparam logic [17:0] DOE_C2 = 18'd73048;
  localparam logic [17:0] DOE_C3 = 18'd109572;
  localparam logic [17:0] DOE_C4 = 18'd146096;

  localparam logic [11:0] YEAR_ERA4 = 12'd1600;
  localparam logic [11:0] YEAR_ERA5 = 12'd2000;

  // Day of year (March based) at which month index mp starts
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ntp_reply_to_calendar_date.sv =====
// ============================================================================
// ntp_reply_to_calendar_date - NTP reply check and local civil date
// Validates one reply's header facts and converts its transmit time plus
// the zone offset into year, month, day, hour, minute and second.
// ============================================================================
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+------------------
//  reply in  | payload_length .. transmit_seconds        | start && !busy
//  config    | cfg_wdata (signed minutes)                | cfg_we
//  result    | reply_valid, year .. second               | done, one cycle
//
//  Nine register stages; a beat may enter every cycle and its result
//  strobes on done together with the output fields. busy is always low.
//  Depth is set by the chain of constant-reciprocal multiplies (days,
//  minutes, hours, day-of-era, year-of-era, month).
//  Synchronous reset clears the stage valid bits and the zone offset;
//  beats in flight are dropped. The receiver cannot stall.
//
`default_nettype none

module ntp_reply_to_calendar_date (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic signed [11:0] cfg_wdata,
  input  logic [15:0]        payload_length,
  input  logic [15:0]        source_port,
  input  logic               address_match,
  input  logic [7:0]         header_byte,
  input  logic [7:0]         stratum_byte,
  input  logic [31:0]        transmit_seconds,
  output logic               done,
  output logic               reply_valid,
  output logic [10:0]        year,
  output logic [3:0]         month,
  output logic [4:0]         day,
  output logic [4:0]         hour,
  output logic [5:0]         minute,
  output logic [5:0]         second
);
  import ntpcal_pkg::*;

  // zone offset held in seconds (minutes * 60), 18-bit two's complement
  logic [17:0] zone_seconds;
  logic [17:0] zone_ext;
  logic [17:0] zone_seconds_next;

  logic                 accept;
  logic [LATENCY-2:0]   stage_vld;

  // stage registers
  logic        s1_ok;  logic [30:0] s1_u;
  logic        s2_ok;  logic [14:0] s2_q;  logic [23:0] s2_x;  logic [6:0] s2_lo;
  logic        s3_ok;  logic [16:0] s3_sod; logic [17:0] s3_doe; logic s3_era5;
  logic        s4_ok;  logic [16:0] s4_sod; logic [10:0] s4_mins;
  logic [17:0] s4_doe; logic [6:0] s4_d1460; logic s4_era5;
  logic        s5_ok;  logic [10:0] s5_mins; logic [5:0] s5_sec;
  logic [17:0] s5_n;   logic [17:0] s5_doe;  logic s5_era5;
  logic        s6_ok;  logic [10:0] s6_mins; logic [4:0] s6_hr; logic [5:0] s6_sec;
  logic [8:0]  s6_yoe; logic [17:0] s6_doe;  logic s6_era5;
  logic        s7_ok;  logic [4:0] s7_hr; logic [5:0] s7_min; logic [5:0] s7_sec;
  logic [8:0]  s7_yoe; logic [8:0] s7_doy; logic s7_era5;
  logic        s8_ok;  logic [4:0] s8_hr; logic [5:0] s8_min; logic [5:0] s8_sec;
  logic [8:0]  s8_yoe; logic [8:0] s8_doy; logic [3:0] s8_mp; logic s8_era5;

  // combinational per stage
  logic        c1_ok;
  logic [32:0] c1_sum;
  logic [48:0] c2_prod;
  logic [24:0] c3_q675;
  logic [23:0] c3_rem;
  logic        c3_era5;
  logic [17:0] c3_doe;
  logic [30:0] c4_mprod;
  logic [31:0] c4_dprod;
  logic [16:0] c5_m60;
  logic [2:0]  c5_cent;
  logic [17:0] c5_n;
  logic [18:0] c6_hprod;
  logic [36:0] c6_yprod;
  logic [10:0] c7_h60;
  logic [1:0]  c7_c100;
  logic [17:0] c7_ydays;
  logic [17:0] c7_doy;
  logic [23:0] c8_mprod;
  logic [8:0]  c9_day;
  logic [11:0] c9_year;
  logic [3:0]  c9_month;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // zone offset in seconds: m * 64 - m * 4
  assign zone_ext          = {{6{cfg_wdata[11]}}, cfg_wdata};
  assign zone_seconds_next = (zone_ext << 6) - (zone_ext << 2);

  // stage 1: header checks, biased local time
  assign c1_ok  = (source_port == NTP_PORT) && (payload_length >= NTP_MIN_LENGTH) &&
                  address_match && (header_byte[2:0] == NTP_MODE_SRV) &&
                  (stratum_byte != 8'd0) && (transmit_seconds > NTP_EPOCH_DELTA);
  assign c1_sum = {1'b0, transmit_seconds} + {{15{zone_seconds[17]}}, zone_seconds}
                  - BIASED_DELTA;

  // stage 2: biased days = (u >> 7) / 675
  assign c2_prod = {25'd0, s1_u[30:7]} * {24'd0, RCP_675};

  // stage 3: seconds of day, day of era
  assign c3_q675 = {10'd0, s2_q} * 25'd675;
  assign c3_rem  = s2_x - c3_q675[23:0];
  assign c3_era5 = (s2_q >= ERA5_Q);
  assign c3_doe  = c3_era5 ? ({3'd0, s2_q} - {3'd0, ERA5_Q})
                           : ({3'd0, s2_q} + ERA4_SHIFT);

  // stage 4: minutes of day, doe / 1460
  assign c4_mprod = {16'd0, s3_sod[16:2]} * {15'd0, RCP_15A};
  assign c4_dprod = {16'd0, s3_doe[17:2]} * {16'd0, RCP_365A};

  // stage 5: second, leap-corrected day count
  assign c5_m60  = {6'd0, s4_mins} * 17'd60;
  assign c5_cent = 3'((s4_doe >= DOE_C1)) + 3'((s4_doe >= DOE_C2)) +
                   3'((s4_doe >= DOE_C3)) + 3'((s4_doe >= DOE_C4));
  assign c5_n    = s4_doe - {11'd0, s4_d1460} + {15'd0, c5_cent}
                   - {17'd0, (s4_doe >= DOE_C4)};

  // stage 6: hour, year of era
  assign c6_hprod = {10'd0, s5_mins[10:2]} * {9'd0, RCP_15B};
  assign c6_yprod = {19'd0, s5_n} * {18'd0, RCP_365B};

  // stage 7: minute, day of year
  assign c7_h60   = {6'd0, s6_hr} * 11'd60;
  assign c7_c100  = 2'((s6_yoe >= 9'd100)) + 2'((s6_yoe >= 9'd200)) +
                    2'((s6_yoe >= 9'd300));
  assign c7_ydays = {9'd0, s6_yoe} * 18'd365 + {11'd0, s6_yoe[8:2]} - {16'd0, c7_c100};
  assign c7_doy   = s6_doe - c7_ydays;

  // stage 8: March-based month index
  assign c8_mprod = {15'd0, s7_doy} * {9'd0, MP_MUL} + MP_ADD;

  // stage 9: day, month, year
  assign c9_day   = s8_doy - month_start(s8_mp) + 9'd1;
  assign c9_month = (s8_mp < 4'd10) ? (s8_mp + 4'd3) : (s8_mp - 4'd9);
  assign c9_year  = (s8_era5 ? YEAR_ERA5 : YEAR_ERA4) + {3'd0, s8_yoe}
                    + {11'd0, (s8_mp >= 4'd10)};

  // control: config register, valid bits, strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_seconds <= 18'd0;
      stage_vld    <= '0;
      done         <= 1'b0;
    end else begin
      if (cfg_we) begin
        zone_seconds <= zone_seconds_next;
      end
      stage_vld <= {stage_vld[LATENCY-3:0], accept};
      done      <= stage_vld[LATENCY-2];
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    s1_ok <= c1_ok;
    s1_u  <= c1_sum[30:0];

    s2_ok <= s1_ok;
    s2_q  <= c2_prod[48:34];
    s2_x  <= s1_u[30:7];
    s2_lo <= s1_u[6:0];

    s3_ok   <= s2_ok;
    s3_sod  <= {c3_rem[9:0], s2_lo};
    s3_doe  <= c3_doe;
    s3_era5 <= c3_era5;

    s4_ok    <= s3_ok;
    s4_sod   <= s3_sod;
    s4_mins  <= c4_mprod[29:19];
    s4_doe   <= s3_doe;
    s4_d1460 <= c4_dprod[30:24];
    s4_era5  <= s3_era5;

    s5_ok   <= s4_ok;
    s5_mins <= s4_mins;
    s5_sec  <= 6'(s4_sod - c5_m60);
    s5_n    <= c5_n;
    s5_doe  <= s4_doe;
    s5_era5 <= s4_era5;

    s6_ok   <= s5_ok;
    s6_mins <= s5_mins;
    s6_hr   <= c6_hprod[17:13];
    s6_sec  <= s5_sec;
    s6_yoe  <= c6_yprod[35:27];
    s6_doe  <= s5_doe;
    s6_era5 <= s5_era5;

    s7_ok   <= s6_ok;
    s7_hr   <= s6_hr;
    s7_min  <= 6'(s6_mins - c7_h60);
    s7_sec  <= s6_sec;
    s7_yoe  <= s6_yoe;
    s7_doy  <= c7_doy[8:0];
    s7_era5 <= s6_era5;

    s8_ok   <= s7_ok;
    s8_hr   <= s7_hr;
    s8_min  <= s7_min;
    s8_sec  <= s7_sec;
    s8_yoe  <= s7_yoe;
    s8_doy  <= s7_doy;
    s8_mp   <= c8_mprod[22:19];
    s8_era5 <= s7_era5;

    // result beat; invalid replies give all zero fields
    reply_valid <= s8_ok;
    if (s8_ok) begin
      year   <= c9_year[10:0];
      month  <= c9_month;
      day    <= c9_day[4:0];
      hour   <= s8_hr;
      minute <= s8_min;
      second <= s8_sec;
    end else begin
      year   <= 11'd0;
      month  <= 4'd0;
      day    <= 5'd0;
      hour   <= 5'd0;
      minute <= 6'd0;
      second <= 6'd0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ntpcal_checker.sv =====
// ============================================================================
// ntpcal_checker - port-level checks for ntp_reply_to_calendar_date
// Latency of accepted beats, zeroing of rejected replies, field ranges.
// ============================================================================
`default_nettype none

module ntpcal_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [15:0] source_port,
  input logic        done,
  input logic        reply_valid,
  input logic [10:0] year,
  input logic [3:0]  month,
  input logic [4:0]  day,
  input logic [4:0]  hour,
  input logic [5:0]  minute,
  input logic [5:0]  second
);
  import ntpcal_pkg::*;

  // every accepted beat strobes a result after the pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(LATENCY) done)
    else $error("accepted beat did not produce a result on time");

  // wrong source port always comes back rejected
  a_port_reject: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && source_port != NTP_PORT) |-> ##(LATENCY) (done && !reply_valid))
    else $error("reply from wrong port not rejected");

  // rejected replies carry zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (done && !reply_valid) |-> (year == 11'd0 && month == 4'd0 && day == 5'd0 &&
                                hour == 5'd0 && minute == 6'd0 && second == 6'd0))
    else $error("rejected reply has nonzero fields");

  // accepted replies carry an in-range month, a nonzero day and a legal time
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    (done && reply_valid) |-> (month >= 4'd1 && month <= 4'd12 && day >= 5'd1 &&
                               hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
    else $error("date or time field out of range");

endmodule

bind ntp_reply_to_calendar_date ntpcal_checker u_ntpcal_checker (.*);

`default_nettype wire
